// ----- sv/lfrq_pkg.sv -----
// Shared definitions for the line-framed receive queue.
// Holds the character codes and the command and status structs that join
// the controller and the datapath. Depends on nothing.
package lfrq_pkg;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // a request is taken this cycle
    logic copy_run;     // copy the assembly buffer into the write slot
    logic commit;       // close the copy: store length, advance write slot
    logic emit_status;  // load one status result into the output register
    logic emit_empty;   // status result reports an empty ring
    logic emit_drop;    // status result reports a dropped line
    logic pop_setup;    // length was read back on accept, count the slot as freed
    logic pop_run;      // stream the oldest line out byte by byte
  } lfrq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_cr;
    logic ring_full;
    logic ring_empty;
    logic copy_done;
    logic pop_done;
    logic out_free;
  } lfrq_sts_t;

endpackage

// ----- sv/lfrq_ctrl.sv -----
// Controller state machine of the line-framed receive queue.
// Sequences line commits, drops, pops and status results through the
// command and status structs of lfrq_pkg.
module lfrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  lfrq_pkg::lfrq_sts_t sts,
  output lfrq_pkg::lfrq_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_COPY  = 7'b0000010,
    ST_STAT  = 7'b0000100,
    ST_DROP  = 7'b0001000,
    ST_EMPTY = 7'b0010000,
    ST_LEN   = 7'b0100000,
    ST_POP   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind) begin
            state_nxt = sts.ring_empty ? ST_EMPTY : ST_LEN;
          end else if (sts.in_is_cr) begin
            state_nxt = sts.ring_full ? ST_DROP : ST_COPY;
          end
        end
      end
      ST_COPY: begin
        cmd.copy_run = 1'b1;
        if (sts.copy_done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_STAT;
        end
      end
      ST_STAT: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          cmd.emit_drop   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          cmd.emit_empty  = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_LEN: begin
        cmd.pop_setup = 1'b1;
        state_nxt     = ST_POP;
      end
      ST_POP: begin
        cmd.pop_run = 1'b1;
        if (sts.pop_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/lfrq_dpath.sv -----
// Datapath of the line-framed receive queue: assembly buffer, slot store,
// slot lengths, ring pointers and the output register.
// Driven by lfrq_ctrl through the structs of lfrq_pkg.
module lfrq_dpath #(
  parameter int LINE_BYTES = 64,
  parameter int LINE_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lfrq_pkg::lfrq_cmd_t cmd,
  output lfrq_pkg::lfrq_sts_t sts,
  input  logic                in_kind,
  input  logic [7:0]          in_rx_byte,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_line_byte,
  output logic                out_last_of_line,
  output logic                out_queue_empty,
  output logic                out_line_dropped,
  output logic [3:0]          out_lines_pending
);

  localparam int IW = $clog2(LINE_BYTES);
  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam int SW = $clog2(LINE_SLOTS);
  localparam int PW = $clog2(LINE_SLOTS + 1);
  localparam int AW = $clog2(LINE_SLOTS * LINE_BYTES);

  logic [7:0]    asm_mem   [LINE_BYTES];
  logic [7:0]    store_mem [LINE_SLOTS * LINE_BYTES];
  logic [LW-1:0] len_mem   [LINE_SLOTS];

  logic [7:0]    asm_rd_r;
  logic [7:0]    store_rd_r;
  logic [LW-1:0] len_rd_r;

  logic [IW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] ws_r, ws_nxt;
  logic [SW-1:0] rs_r, rs_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          last_pend_r, last_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_empty_r;
  logic          out_drop_r;
  logic [3:0]    out_pend_r;

  logic          is_cr;
  logic          is_nul;
  logic          out_free;
  logic          byte_acc;
  logic          pop_acc;
  logic          copy_rd;
  logic          copy_wr;
  logic          pop_load;
  logic          pop_issue;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign is_cr    = (in_rx_byte == lfrq_pkg::CHAR_CR);
  assign is_nul   = (in_rx_byte == lfrq_pkg::CHAR_NUL);
  assign out_free = !out_valid_r || out_ready;
  assign byte_acc = cmd.accept && !in_kind;
  assign pop_acc  = cmd.accept && in_kind;

  // The copy reads byte cnt while it writes byte cnt-1 read the cycle before.
  assign copy_rd  = cmd.copy_run && (cnt_r != len_r);
  assign copy_wr  = cmd.copy_run && (cnt_r != '0);
  assign wr_addr  = AW'(ws_r) * AW'(LINE_BYTES) + AW'(cnt_r) - AW'(1);

  // Pop: the store read register holds one byte ahead of the output register.
  assign pop_load  = cmd.pop_run && rd_pend_r && out_free;
  assign pop_issue = cmd.pop_run && (cnt_r != len_rd_r) && (!rd_pend_r || pop_load);
  assign rd_addr   = AW'(rs_r) * AW'(LINE_BYTES) + AW'(cnt_r);

  assign sts.in_is_cr   = is_cr;
  assign sts.ring_full  = (pend_r == PW'(LINE_SLOTS));
  assign sts.ring_empty = (pend_r == '0);
  assign sts.copy_done  = (cnt_r == len_r);
  assign sts.pop_done   = pop_load && last_pend_r;
  assign sts.out_free   = out_free;

  always_comb begin
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    ws_nxt        = ws_r;
    rs_nxt        = rs_r;
    pend_nxt      = pend_r;
    rd_pend_nxt   = rd_pend_r;
    last_pend_nxt = last_pend_r;

    if (byte_acc) begin
      if (is_cr) begin
        len_nxt = LW'(idx_r) + LW'(1);
        cnt_nxt = '0;
      end else if (!is_nul) begin
        idx_nxt = (idx_r == IW'(LINE_BYTES - 1)) ? '0 : idx_r + IW'(1);
      end
    end
    if (pop_acc) begin
      cnt_nxt = '0;
    end
    if (copy_rd) begin
      cnt_nxt = cnt_r + LW'(1);
    end
    if (cmd.commit) begin
      idx_nxt  = '0;
      ws_nxt   = (ws_r == SW'(LINE_SLOTS - 1)) ? '0 : ws_r + SW'(1);
      pend_nxt = pend_r + PW'(1);
    end
    if (cmd.emit_drop) begin
      idx_nxt = '0;
    end
    if (cmd.pop_setup) begin
      pend_nxt = pend_r - PW'(1);
    end
    if (pop_issue) begin
      cnt_nxt       = cnt_r + LW'(1);
      rd_pend_nxt   = 1'b1;
      last_pend_nxt = ((cnt_r + LW'(1)) == len_rd_r);
    end else if (pop_load) begin
      rd_pend_nxt = 1'b0;
    end
    // The read slot moves on once its last byte has left.
    if (pop_load && last_pend_r) begin
      rs_nxt = (rs_r == SW'(LINE_SLOTS - 1)) ? '0 : rs_r + SW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop_load || cmd.emit_status) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      ws_r        <= '0;
      rs_r        <= '0;
      pend_r      <= '0;
      rd_pend_r   <= 1'b0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      ws_r        <= ws_nxt;
      rs_r        <= rs_nxt;
      pend_r      <= pend_nxt;
      rd_pend_r   <= rd_pend_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_load) begin
      out_byte_r  <= store_rd_r;
      out_last_r  <= last_pend_r;
      out_empty_r <= 1'b0;
      out_drop_r  <= 1'b0;
      out_pend_r  <= 4'(pend_r);
    end else if (cmd.emit_status) begin
      out_byte_r  <= lfrq_pkg::CHAR_NUL;
      out_last_r  <= 1'b0;
      out_empty_r <= cmd.emit_empty;
      out_drop_r  <= cmd.emit_drop;
      out_pend_r  <= 4'(pend_r);
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      asm_mem[idx_r] <= in_rx_byte;
    end
    if (copy_rd) begin
      asm_rd_r <= asm_mem[cnt_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (copy_wr) begin
      store_mem[wr_addr] <= asm_rd_r;
    end
    if (pop_issue) begin
      store_rd_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      len_mem[ws_r] <= len_r;
    end
    if (pop_acc) begin
      len_rd_r <= len_mem[rs_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_byte     = out_byte_r;
  assign out_last_of_line  = out_last_r;
  assign out_queue_empty   = out_empty_r;
  assign out_line_dropped  = out_drop_r;
  assign out_lines_pending = out_pend_r;

endmodule

// ----- sv/line_framed_receive_queue_top.sv -----
// Line-framed receive queue. A plain byte gives no result.
// A carriage return copies len bytes through the assembly buffer read port
// before its status result; a full ring or an empty pop gives its status
// result with no copy. A pop streams its line from the slot store, one byte
// per cycle while the output is not stalled.
// Synchronous reset clears pointers, counts and handshakes; memories are not.
module line_framed_receive_queue_top #(
  parameter int LINE_BYTES = 64,
  parameter int LINE_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic       out_last_of_line,
  output logic       out_queue_empty,
  output logic       out_line_dropped,
  output logic [3:0] out_lines_pending
);

  lfrq_pkg::lfrq_cmd_t cmd;
  lfrq_pkg::lfrq_sts_t sts;

  lfrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfrq_dpath #(
    .LINE_BYTES (LINE_BYTES),
    .LINE_SLOTS (LINE_SLOTS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_rx_byte        (in_rx_byte),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_line_byte     (out_line_byte),
    .out_last_of_line  (out_last_of_line),
    .out_queue_empty   (out_queue_empty),
    .out_line_dropped  (out_line_dropped),
    .out_lines_pending (out_lines_pending)
  );

`ifndef SYNTH
  // The last byte of a line never carries a status flag.
  a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_line |-> !out_queue_empty && !out_line_dropped)
    else $error("last byte of a line carries a status flag");

  // An empty-ring report shows no byte and no pending lines.
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_empty |-> out_line_byte == 8'h00 && out_lines_pending == 4'd0)
    else $error("empty report carries data");

  // A pop or a line end closes the input on the following cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind || in_rx_byte == lfrq_pkg::CHAR_CR) |=> !in_ready)
    else $error("input reopened during line work");

  // The commit of a line is always followed by its status step, with the input closed.
  a_commit_stat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_ready)
    else $error("commit without a status step");
`endif

endmodule
